// ----- hdl/cppc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated pulse peak capture package
// Shared item types, state codes, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package cppc_pkg;

    localparam int CPPC_CHANNELS = 8;
    localparam int Q_DEPTH       = 4;
    localparam int Q_PTR_W       = $clog2(Q_DEPTH);
    localparam int Q_CNT_W       = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] REG_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_CONFIRM   = 2'd1;
    localparam logic [1:0] REG_RELEASE   = 2'd2;

    localparam logic signed [31:0] THRESHOLD_RST = 32'sd128;
    localparam logic [15:0]        CONFIRM_RST   = 16'd500;
    localparam logic [15:0]        RELEASE_RST   = 16'd5000;
    localparam logic signed [31:0] GAIN_RST      = 32'sh0001_0000;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_LOAD   = 1'b1;

    typedef enum logic [1:0] {
        PS_INACTIVE = 2'd0,
        PS_CONFIRM  = 2'd1,
        PS_ACTIVE   = 2'd2
    } t_pulse_state;

    typedef struct packed {
        logic               mode;
        logic [2:0]         channel;
        logic signed [15:0] sample;
        logic [31:0]        time_ms;
        logic signed [31:0] gain_in;
        logic signed [23:0] offset_in;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         out_channel;
        logic [1:0]         pulse_state;
        logic signed [31:0] calibrated;
        logic signed [31:0] running_peak;
        logic signed [31:0] captured_peak;
        logic               capture_done;
    } t_out_item;

    typedef struct packed {
        logic               mode;
        logic [2:0]         channel;
        logic [14:0]        mag;
        logic [31:0]        time_ms;
        logic signed [31:0] gain;
        logic signed [23:0] offset;
    } t_job;

    typedef struct packed {
        logic               full;
        logic               empty;
        logic [Q_CNT_W-1:0] count;
    } t_q_status;

endpackage

// ----- hdl/calibrated_pulse_peak_capture.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calibrated pulse peak capture
// Per-channel sample calibration, pulse detection and peak latching.
// ----------------------------------------------------------------------------
// Channel | Direction | Handshake            | Payload
// in      | input     | i_in_valid/o_in_stall | t_in_item
// out     | output    | o_out_valid/i_out_stall | t_out_item
// cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_addr, i_cfg_data
//
// One item per cycle sustained while the output is not stalled; a sample item
// passes the queue, offset subtract, multiply, round and channel update in order.
// Calibration loads and out-of-range channels give no result.
// Synchronous active-low reset restores all channels and config registers at once.
// Output stall freezes the back pipeline; the 4-entry queue absorbs input
// until full, which raises o_in_stall.
// ----------------------------------------------------------------------------
module calibrated_pulse_peak_capture #(
    parameter int CHANNELS = cppc_pkg::CPPC_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  cppc_pkg::t_in_item   i_in_data,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output cppc_pkg::t_out_item  o_out_data,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_addr,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_cfg_ready
);
    import cppc_pkg::*;

    logic      push;
    logic      pop;
    t_job      front_job;
    t_job      q_job;
    t_q_status q_status;

    assign o_cfg_ready = 1'b1;

    cppc_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_q_status (q_status),
        .o_push     (push),
        .o_job      (front_job)
    );

    cppc_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (front_job),
        .i_pop    (pop),
        .o_job    (q_job),
        .o_status (q_status)
    );

    cppc_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_job       (q_job),
        .i_q_status  (q_status),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    a_capture_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.capture_done |->
            o_out_data.pulse_state == PS_INACTIVE && o_out_data.running_peak == 32'sd0)
        else $error("capture left channel busy");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_status.count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue overflow");

    a_drop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && 7'(i_in_data.channel) >= 7'(CHANNELS) |-> !push)
        else $error("out-of-range channel queued");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !pop |=> q_status.count == $past(q_status.count) + 1'b1)
        else $error("queue count lost a push");

endmodule

// ----- hdl/cppc_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end
// Accept items, drop out-of-range channels, take the sample magnitude and
// push a job into the queue.
// ----------------------------------------------------------------------------
module cppc_front #(
    parameter int CHANNELS = cppc_pkg::CPPC_CHANNELS
) (
    input  logic                 i_in_valid,
    input  cppc_pkg::t_in_item   i_in_data,
    output logic                 o_in_stall,
    input  cppc_pkg::t_q_status  i_q_status,
    output logic                 o_push,
    output cppc_pkg::t_job       o_job
);
    import cppc_pkg::*;

    logic        in_range;
    logic [15:0] neg_sample;
    logic [14:0] mag;

    assign o_in_stall = i_q_status.full;
    assign in_range   = 7'(i_in_data.channel) < 7'(CHANNELS);
    assign o_push     = i_in_valid && !o_in_stall && in_range;

    // saturate the most negative code
    always_comb begin
        neg_sample = 16'(-i_in_data.sample);
        if (i_in_data.sample == 16'sh8000) begin
            mag = 15'h7fff;
        end else if (i_in_data.sample[15]) begin
            mag = neg_sample[14:0];
        end else begin
            mag = i_in_data.sample[14:0];
        end
    end

    always_comb begin
        o_job.mode    = i_in_data.mode;
        o_job.channel = i_in_data.channel;
        o_job.mag     = mag;
        o_job.time_ms = i_in_data.time_ms;
        o_job.gain    = i_in_data.gain_in;
        o_job.offset  = i_in_data.offset_in;
    end

endmodule

// ----- hdl/cppc_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Job queue
// Short FIFO between front and back so each side stalls on its own.
// ----------------------------------------------------------------------------
module cppc_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  cppc_pkg::t_job       i_job,
    input  logic                 i_pop,
    output cppc_pkg::t_job       o_job,
    output cppc_pkg::t_q_status  o_status
);
    import cppc_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    assign o_job           = r_mem[r_rd];
    assign o_status.full   = r_cnt == Q_CNT_W'(Q_DEPTH);
    assign o_status.empty  = r_cnt == '0;
    assign o_status.count  = r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/cppc_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end
// Calibration pipeline, per-channel pulse tracking and the output register.
// ----------------------------------------------------------------------------
module cppc_back #(
    parameter int CHANNELS = cppc_pkg::CPPC_CHANNELS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_addr,
    input  logic [31:0]          i_cfg_data,
    input  cppc_pkg::t_job       i_job,
    input  cppc_pkg::t_q_status  i_q_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cppc_pkg::t_out_item  o_out_data
);
    import cppc_pkg::*;

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic signed [31:0] r_threshold;
    logic [15:0]        r_confirm;
    logic [15:0]        r_release;

    t_pulse_state       r_state [CHANNELS];
    logic [31:0]        r_stamp [CHANNELS];
    logic signed [31:0] r_peak  [CHANNELS];
    logic signed [31:0] r_cap   [CHANNELS];
    logic signed [31:0] r_gain  [CHANNELS];
    logic signed [23:0] r_offset[CHANNELS];

    logic               r_s1_valid;
    logic [2:0]         r_s1_ch;
    logic [31:0]        r_s1_time;
    logic signed [24:0] r_s1_d;
    logic signed [31:0] r_s1_gain;

    logic               r_s2_valid;
    logic [2:0]         r_s2_ch;
    logic [31:0]        r_s2_time;
    logic signed [56:0] r_s2_prod;

    logic               r_s3_valid;
    logic [2:0]         r_s3_ch;
    logic [31:0]        r_s3_time;
    logic signed [31:0] r_s3_cal;

    logic               r_out_valid;
    t_out_item          r_out;

    logic               adv;
    logic [IDX_W-1:0]   idx0;
    logic [IDX_W-1:0]   idx3;
    logic signed [24:0] d;
    logic signed [56:0] rnd;
    logic [9:0]         hi;
    logic signed [31:0] cal;

    t_pulse_state       cur_st;
    t_pulse_state       n_st;
    logic [31:0]        n_stamp;
    logic signed [31:0] n_peak;
    logic signed [31:0] n_cap;
    logic               n_done;
    logic               above;
    logic [31:0]        elapsed;

    assign adv         = !r_out_valid || !i_out_stall;
    assign o_pop       = adv && !i_q_status.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_confirm   <= CONFIRM_RST;
            r_release   <= RELEASE_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_THRESHOLD: r_threshold <= i_cfg_data;
                REG_CONFIRM:   r_confirm   <= i_cfg_data[15:0];
                REG_RELEASE:   r_release   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // stage 1: calibration load or offset subtract
    assign idx0 = IDX_W'(i_job.channel);
    assign d    = $signed({2'b00, i_job.mag, 8'h00})
                - $signed({r_offset[idx0][23], r_offset[idx0]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_gain[i]   <= GAIN_RST;
                r_offset[i] <= '0;
            end
        end else if (o_pop && i_job.mode == MODE_LOAD) begin
            r_gain[idx0]   <= i_job.gain;
            r_offset[idx0] <= i_job.offset;
        end
    end

    // stages 2 and 3: multiply, then round and saturate
    assign rnd = r_s2_prod + 57'sd32768;
    assign hi  = rnd[56:47];

    always_comb begin
        if ((&hi) || !(|hi)) begin
            cal = rnd[47:16];
        end else if (hi[9]) begin
            cal = 32'sh8000_0000;
        end else begin
            cal = 32'sh7fff_ffff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid  <= o_pop && i_job.mode == MODE_SAMPLE;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_ch   <= i_job.channel;
            r_s1_time <= i_job.time_ms;
            r_s1_d    <= d;
            r_s1_gain <= r_gain[idx0];
            r_s2_ch   <= r_s1_ch;
            r_s2_time <= r_s1_time;
            r_s2_prod <= r_s1_gain * r_s1_d;
            r_s3_ch   <= r_s2_ch;
            r_s3_time <= r_s2_time;
            r_s3_cal  <= cal;
            r_out.out_channel   <= r_s3_ch;
            r_out.pulse_state   <= n_st;
            r_out.calibrated    <= r_s3_cal;
            r_out.running_peak  <= n_peak;
            r_out.captured_peak <= n_cap;
            r_out.capture_done  <= n_done;
        end
    end

    // stage 4: pulse tracking
    assign idx3    = IDX_W'(r_s3_ch);
    assign cur_st  = r_state[idx3];
    assign above   = r_s3_cal > r_threshold;
    assign elapsed = r_s3_time - r_stamp[idx3];

    always_comb begin
        n_st    = cur_st;
        n_stamp = r_stamp[idx3];
        n_peak  = r_peak[idx3];
        n_cap   = r_cap[idx3];
        n_done  = 1'b0;
        if (above) begin
            unique case (cur_st)
                PS_INACTIVE: begin
                    n_st    = PS_CONFIRM;
                    n_peak  = '0;
                    n_stamp = r_s3_time;
                end
                PS_CONFIRM: begin
                    if (elapsed > {16'h0000, r_confirm}) begin
                        n_st    = PS_ACTIVE;
                        n_stamp = r_s3_time;
                    end
                end
                PS_ACTIVE: begin
                    if (r_s3_cal > r_peak[idx3]) begin
                        n_peak = r_s3_cal;
                    end
                    n_stamp = r_s3_time;
                end
                default: n_st = PS_INACTIVE;
            endcase
        end else if (cur_st == PS_ACTIVE && elapsed > {16'h0000, r_release}) begin
            n_st    = PS_INACTIVE;
            n_cap   = r_peak[idx3];
            n_peak  = '0;
            n_stamp = '0;
            n_done  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CHANNELS; i++) begin
                r_state[i] <= PS_INACTIVE;
                r_stamp[i] <= '0;
                r_peak[i]  <= '0;
                r_cap[i]   <= '0;
            end
        end else if (adv && r_s3_valid) begin
            r_state[idx3] <= n_st;
            r_stamp[idx3] <= n_stamp;
            r_peak[idx3]  <= n_peak;
            r_cap[idx3]   <= n_cap;
        end
    end

endmodule
